// File: sv/mlpq_pkg.sv
// shared constants, status and mode codes for the multilevel priority ready queue
// no dependencies
`default_nettype none
package mlpq_pkg;
  localparam int MAX_LEVELS_DEF  = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam logic [3:0] ACTIVE_LEVELS_RST = 4'd4;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_REM = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ILLEGAL   = 3'd1;
  localparam logic [2:0] ST_INTERRUPT = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture request, set up level
    logic rd;       // select first non-empty level for dequeue, rewind scan
    logic step;     // advance scan position
    logic wr_shift; // write shifted word back at previous position
    logic wr_enq;   // append word
    logic pop;      // decrement occupancy of level
    logic push;     // increment occupancy of level
  } mlpq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic legal;     // level below active count
    logic full;      // level holds depth entries
    logic empty;     // chosen level empty (dequeue: all empty)
    logic scan_last; // scan position at last occupied entry
    logic match;     // read word equals request id
  } mlpq_sts_t;
endpackage
`default_nettype wire

// File: sv/mlpq_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
`default_nettype none
module mlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/mlpq_dp.sv
// datapath: request register, occupancy counters, entry ram, scan pointer
// depends on mlpq_pkg and mlpq_ram
`default_nettype none
module mlpq_dp
  import mlpq_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] active_levels,
  input  wire logic [7:0] process_id,
  input  wire logic [3:0] priority_req,
  input  wire mlpq_cmd_t  cmd,
  output      mlpq_sts_t  sts,
  output      logic [7:0] rd_word
);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = LW + PW;

  logic [CW-1:0] occ_r [MAX_LEVELS];
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [7:0]    pid_r;
  logic          legal_r, legal_nxt;
  logic          deq_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          found;
  logic [LW-1:0] deq_lvl;
  logic [4:0]    eff;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wpos;
  logic [7:0]    wdata;

  // effective level count, capped
  assign eff = ({1'b0, active_levels} > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS)
                                                       : {1'b0, active_levels};

  // request level and its legality
  assign legal_nxt = ({1'b0, priority_req} < eff);
  assign lvl_nxt   = LW'(priority_req);

  // first non-empty visible level for dequeue
  always_comb begin
    deq_lvl = '0;
    found   = 1'b0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (5'(l) < eff && occ_r[l] != '0) begin
        deq_lvl = LW'(l);
        found   = 1'b1;
      end
    end
  end

  // request register; dequeue replaces the level with the chosen one
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid_r   <= process_id;
      deq_r   <= 1'b0;
      lvl_r   <= lvl_nxt;
      legal_r <= legal_nxt;
    end else if (cmd.rd) begin
      lvl_r   <= deq_lvl;
      legal_r <= found;
      deq_r   <= 1'b1;
    end
  end

  // scan position
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load || cmd.rd) begin
      pos_nxt = '0;
    end else if (cmd.step) begin
      pos_nxt = pos_r + PW'(1);
    end
  end
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  // occupancy counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < MAX_LEVELS; l++) occ_r[l] <= '0;
    end else if (cmd.push) begin
      occ_r[lvl_r] <= occ_r[lvl_r] + CW'(1);
    end else if (cmd.pop) begin
      occ_r[lvl_r] <= occ_r[lvl_r] - CW'(1);
    end
  end

  // entry ram: read at scan position, write appended or shifted word
  assign we    = cmd.wr_enq | cmd.wr_shift;
  assign wpos  = cmd.wr_enq ? PW'(occ_r[lvl_r]) : (pos_r - PW'(1));
  assign waddr = {lvl_r, wpos};
  assign wdata = cmd.wr_enq ? pid_r : rd_word;
  assign raddr = {lvl_r, pos_r};

  mlpq_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_word)
  );

  // status to controller
  assign sts.legal     = legal_r;
  assign sts.full      = (occ_r[lvl_r] == CW'(LEVEL_DEPTH));
  assign sts.empty     = deq_r ? !legal_r : (occ_r[lvl_r] == '0);
  assign sts.scan_last = (CW'(pos_r) + CW'(1) >= occ_r[lvl_r]);
  assign sts.match     = (rd_word == pid_r);
endmodule
`default_nettype wire

// File: sv/mlpq_ctrl.sv
// controller: sequences enqueue, dequeue and remove over the datapath
// depends on mlpq_pkg
`default_nettype none
module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_mode,
  input  wire logic       in_interrupt_process,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] out_status,
  output      logic [7:0] out_result_id,
  output      logic       busy,
  output      mlpq_cmd_t  cmd,
  input  wire mlpq_sts_t  sts,
  input  wire logic [7:0] rd_word
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DQSEL  = 3'd2;
  localparam logic [2:0] S_RDW    = 3'd3;
  localparam logic [2:0] S_SCHK   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] mode_r;
  logic       intr_r;
  logic       ov_r, ov_nxt;
  logic [2:0] st_r, st_nxt;
  logic [7:0] id_r, id_nxt;
  logic       hit_r, hit_nxt;
  logic       take;

  assign take     = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign busy     = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      intr_r <= in_interrupt_process;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    ov_nxt    = ov_r && !out_ready;
    st_nxt    = st_r;
    id_nxt    = id_r;
    hit_nxt   = hit_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        id_nxt    = '0;
        hit_nxt   = 1'b0;
        case (mode_r)
          MODE_ENQ: begin
            if (!sts.legal) st_nxt = ST_ILLEGAL;
            else if (intr_r) st_nxt = ST_INTERRUPT;
            else if (sts.full) st_nxt = ST_FULL;
            else begin
              st_nxt     = ST_OK;
              cmd.wr_enq = 1'b1;
              cmd.push   = 1'b1;
            end
          end
          MODE_DEQ: begin
            cmd.rd    = 1'b1;
            ov_nxt    = 1'b0;
            state_nxt = S_DQSEL;
          end
          MODE_REM: begin
            if (!sts.legal || sts.empty) st_nxt = ST_NONE;
            else begin
              // word at position zero is being read
              ov_nxt    = 1'b0;
              state_nxt = S_SCHK;
            end
          end
          default: st_nxt = ST_ILLEGAL;
        endcase
      end
      S_DQSEL: begin
        // level chosen; word at position zero is being read
        if (sts.empty) begin
          st_nxt    = ST_NONE;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_RDW: begin
        // read in flight at the new position
        state_nxt = hit_r ? S_SHIFT : S_SCHK;
      end
      S_SCHK: begin
        // read word belongs to the current position
        if (mode_r == MODE_DEQ || sts.match) begin
          id_nxt  = rd_word;
          hit_nxt = 1'b1;
          if (sts.scan_last) begin
            cmd.pop   = 1'b1;
            st_nxt    = ST_OK;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_RDW;
          end
        end else if (sts.scan_last) begin
          st_nxt    = ST_NONE;
          id_nxt    = '0;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RDW;
        end
      end
      S_SHIFT: begin
        // word of the current position moves one place down
        cmd.wr_shift = 1'b1;
        if (sts.scan_last) begin
          cmd.pop   = 1'b1;
          st_nxt    = ST_OK;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RDW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    st_r  <= st_nxt;
    id_r  <= id_nxt;
    hit_r <= hit_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_result_id = id_r;
endmodule
`default_nettype wire

// File: sv/multilevel_priority_ready_queue.sv
// top level: configuration register, controller and datapath
// depends on mlpq_pkg, mlpq_ctrl, mlpq_dp
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, mode, id, prio, intr   | in
//  out     | out_valid/out_ready, status, result_id     | out
//  cfg     | cfg_valid/cfg_ready, cfg_active_levels     | in
//
// enqueue and refusals are answered in the decide state, an empty dequeue in the
// level select state; dequeue and remove scan the level with one ram read per
// scanned position and move each later word one place down
// one request at a time; the result waits in the output register while stalled
// and the next word is taken in the cycle it leaves; cfg waits while busy
// reset clears occupancy counters; entry storage is never cleared
`default_nettype none
module multilevel_priority_ready_queue
  import mlpq_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_process_id,
  input  wire logic [3:0] in_priority_req,
  input  wire logic       in_interrupt_process,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] out_status,
  output      logic [7:0] out_result_id,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [3:0] cfg_active_levels
);
  logic [3:0] active_levels_r;
  logic       busy;
  mlpq_cmd_t  cmd;
  mlpq_sts_t  sts;
  logic [7:0] rd_word;

  // configuration register, written only with no request in flight or offered
  assign cfg_ready = !busy && !in_valid;
  always_ff @(posedge clk) begin
    if (!rst_n) active_levels_r <= ACTIVE_LEVELS_RST;
    else if (cfg_valid && cfg_ready) active_levels_r <= cfg_active_levels;
  end

  mlpq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_interrupt_process,
    .out_valid, .out_ready, .out_status, .out_result_id, .busy,
    .cmd, .sts, .rd_word
  );

  mlpq_dp #(.MAX_LEVELS(MAX_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_dp (
    .clk, .rst_n, .active_levels(active_levels_r), .process_id(in_process_id),
    .priority_req(in_priority_req), .cmd, .sts, .rd_word
  );
endmodule
`default_nettype wire

// File: sv/mlpq_checker.sv
// port level checker for the multilevel priority ready queue, with bind
// depends on mlpq_pkg
`default_nettype none
module mlpq_checker
  import mlpq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_result_id
);
  // result word stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_id))
    else $error("result word changed while stalled");
  // refused requests carry a zero id
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_id == 8'd0)
    else $error("nonzero id with error status");
  // status code in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE)
    else $error("bad status");
  // no new request taken right after another
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back to back accept");
endmodule

bind multilevel_priority_ready_queue mlpq_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_result_id
);
`default_nettype wire
